/* design/skgs_pkg.sv */
`timescale 1ns / 1ps

package skgs_pkg;

  localparam int unsigned MAX_RECORDS = 64;

  localparam int unsigned KEY_W  = 64;
  localparam int unsigned REV_W  = 32;
  localparam int unsigned DISC_W = 17;
  localparam int unsigned SUM_W  = 48;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned PROD_W = REV_W + DISC_W;

  localparam logic [DISC_W-1:0] ONE_Q16 = DISC_W'(65536);
  localparam logic [SUM_W-1:0]  SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_CAP = CNT_W'(MAX_RECORDS);

  typedef struct packed {
    logic mul_en;  // register the product of revenue and scale
    logic acc_en;  // add the product into the running sum
    logic clr;     // clear the running sum
  } mac_ctrl_t;

endpackage

/* design/skgs_if.sv */
`timescale 1ns / 1ps

interface skgs_in_if import skgs_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  key;
  logic [REV_W-1:0]  revenue;
  logic [DISC_W-1:0] discount;
  logic              last;

  modport source (output valid, key, revenue, discount, last, input ready);
  modport sink (input valid, key, revenue, discount, last, output ready);
endinterface

interface skgs_out_if import skgs_pkg::*;;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] out_key;
  logic [SUM_W-1:0] group_sum;
  logic [CNT_W-1:0] group_count;
  logic             overflow;
  logic             end_of_run;

  modport source (output valid, out_key, group_sum, group_count, overflow, end_of_run,
                  input ready);
  modport sink (input valid, out_key, group_sum, group_count, overflow, end_of_run,
                output ready);
endinterface

/* design/skgs_mac.sv */
`timescale 1ns / 1ps

module skgs_mac import skgs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mac_ctrl_t         ctrl_i,
  input  logic [REV_W-1:0]  revenue_i,
  input  logic [DISC_W-1:0] discount_i,
  output logic [SUM_W-1:0]  sum_o,
  output logic              sat_o
);

  logic [DISC_W-1:0]  disc_sat;
  logic [DISC_W-1:0]  scale;
  logic [PROD_W-1:0]  prod_d;
  logic [PROD_W-1:0]  prod_q;
  logic [PROD_W-17:0] term;
  logic [SUM_W:0]     acc;
  logic [SUM_W-1:0]   sum_q;

  always_comb begin
    disc_sat = (discount_i > ONE_Q16) ? ONE_Q16 : discount_i;
    scale    = ONE_Q16 - disc_sat;
    prod_d   = PROD_W'(revenue_i) * PROD_W'(scale);
    term     = prod_q[PROD_W-1:16];
    acc      = (SUM_W+1)'(sum_q) + (SUM_W+1)'(term);
  end

  assign sat_o = acc[SUM_W];
  assign sum_o = sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      sum_q  <= '0;
    end else begin
      if (ctrl_i.mul_en) begin
        prod_q <= prod_d;
      end
      if (ctrl_i.clr) begin
        sum_q <= '0;
      end else if (ctrl_i.acc_en) begin
        sum_q <= acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
      end
    end
  end

endmodule

/* design/sorted_key_group_sum_count.sv */
`timescale 1ns / 1ps
// steps: a record is taken in S_IDLE, multiplied in S_MUL and accumulated in S_ADD;
// a key change first drains the closed group at one result per cycle while res_o
// is not stalled; throughput: one record per pass through S_MUL and S_ADD, a record
// dropped past capacity every cycle, but a group its last mark closes drains first;
// the shared multiply-accumulate unit and the result sequencer set this
// reset: asynchronous active-low, clears the open group, counters and overflow flag

module sorted_key_group_sum_count import skgs_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  skgs_in_if.sink    rec_i,
  skgs_out_if.source res_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT_OLD,
    S_MUL,
    S_ADD,
    S_EMIT_FINAL
  } state_e;

  state_e            state_q;
  logic [KEY_W-1:0]  key_q;
  logic [REV_W-1:0]  revenue_q;
  logic [DISC_W-1:0] discount_q;
  logic              last_q;
  logic [KEY_W-1:0]  prev_key_q;
  logic [CNT_W-1:0]  run_cnt_q;
  logic [CNT_W-1:0]  seen_q;
  logic [CNT_W-1:0]  emit_cnt_q;
  logic              ovf_q;

  logic              res_valid_q;
  logic [KEY_W-1:0]  res_key_q;
  logic [SUM_W-1:0]  res_sum_q;
  logic [CNT_W-1:0]  res_cnt_q;
  logic              res_ovf_q;
  logic              res_eor_q;

  mac_ctrl_t         mac_ctrl;
  logic [SUM_W-1:0]  sum;
  logic              sat;
  logic              emitting;
  logic              emit_go;
  logic              group_done;
  logic              rec_acc;
  logic              drop;

  skgs_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (mac_ctrl),
    .revenue_i  (revenue_q),
    .discount_i (discount_q),
    .sum_o      (sum),
    .sat_o      (sat)
  );

  always_comb begin
    emitting       = (state_q == S_EMIT_OLD) || (state_q == S_EMIT_FINAL);
    emit_go        = emitting && (!res_valid_q || res_o.ready);
    group_done     = (emit_cnt_q + CNT_W'(1)) == run_cnt_q;
    rec_acc        = rec_i.valid && (state_q == S_IDLE);
    drop           = seen_q >= CNT_CAP;
    mac_ctrl.mul_en = (state_q == S_MUL);
    mac_ctrl.acc_en = (state_q == S_ADD);
    mac_ctrl.clr    = emit_go && group_done;
  end

  assign rec_i.ready       = (state_q == S_IDLE);
  assign res_o.valid       = res_valid_q;
  assign res_o.out_key     = res_key_q;
  assign res_o.group_sum   = res_sum_q;
  assign res_o.group_count = res_cnt_q;
  assign res_o.overflow    = res_ovf_q;
  assign res_o.end_of_run  = res_eor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      key_q       <= '0;
      revenue_q   <= '0;
      discount_q  <= '0;
      last_q      <= 1'b0;
      prev_key_q  <= '0;
      run_cnt_q   <= '0;
      seen_q      <= '0;
      emit_cnt_q  <= '0;
      ovf_q       <= 1'b0;
      res_valid_q <= 1'b0;
      res_key_q   <= '0;
      res_sum_q   <= '0;
      res_cnt_q   <= '0;
      res_ovf_q   <= 1'b0;
      res_eor_q   <= 1'b0;
    end else begin
      if (res_valid_q && res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (rec_acc) begin
            key_q      <= rec_i.key;
            revenue_q  <= rec_i.revenue;
            discount_q <= rec_i.discount;
            last_q     <= rec_i.last;
            emit_cnt_q <= '0;
            if (drop) begin
              // dropped record: it only sets the overflow flag and acts on its last mark
              ovf_q <= 1'b1;
              if (rec_i.last) begin
                if (run_cnt_q != '0) begin
                  state_q <= S_EMIT_FINAL;
                end else begin
                  prev_key_q <= '0;
                  seen_q     <= '0;
                  ovf_q      <= 1'b0;
                end
              end
            end else if (run_cnt_q != '0 && rec_i.key != prev_key_q) begin
              state_q <= S_EMIT_OLD;
            end else begin
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          state_q <= S_ADD;
        end
        S_ADD: begin
          prev_key_q <= key_q;
          run_cnt_q  <= run_cnt_q + CNT_W'(1);
          seen_q     <= seen_q + CNT_W'(1);
          emit_cnt_q <= '0;
          if (sat) begin
            ovf_q <= 1'b1;
          end
          state_q <= last_q ? S_EMIT_FINAL : S_IDLE;
        end
        S_EMIT_OLD, S_EMIT_FINAL: begin
          if (emit_go) begin
            res_valid_q <= 1'b1;
            res_key_q   <= prev_key_q;
            res_sum_q   <= sum;
            res_cnt_q   <= run_cnt_q;
            res_ovf_q   <= ovf_q;
            res_eor_q   <= (state_q == S_EMIT_FINAL) && group_done;
            emit_cnt_q  <= emit_cnt_q + CNT_W'(1);
            if (group_done) begin
              run_cnt_q  <= '0;
              emit_cnt_q <= '0;
              if (state_q == S_EMIT_OLD) begin
                state_q <= S_MUL;
              end else begin
                // end of sequence: back to the reset state
                prev_key_q <= '0;
                seen_q     <= '0;
                ovf_q      <= 1'b0;
                state_q    <= S_IDLE;
              end
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> res_cnt_q != '0)
    else $error("result with empty group");

  a_seen_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= CNT_CAP)
    else $error("accepted records beyond capacity");

  a_run_le_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_cnt_q <= seen_q)
    else $error("open group larger than records seen");

  a_emit_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emitting |-> (run_cnt_q != '0 && emit_cnt_q < run_cnt_q))
    else $error("emitting without an open group");

  a_eor_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_go && state_q == S_EMIT_FINAL && group_done) |=>
      (seen_q == '0 && run_cnt_q == '0 && !ovf_q))
    else $error("sequence state not cleared after final result");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
  import skgs_pkg::*;

  typedef struct {
    logic [KEY_W-1:0]  key;
    logic [REV_W-1:0]  revenue;
    logic [DISC_W-1:0] discount;
    logic              last;
    bit                drain;   // hold this item back until every owed result is out
  } record_t;

  typedef struct {
    logic [KEY_W-1:0] key;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic             ovf;
    logic             eor;
  } group_row_t;

  logic clk_i;
  logic rst_ni;

  skgs_in_if  rec_if ();
  skgs_out_if res_if ();

  sorted_key_group_sum_count u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rec_i  (rec_if),
    .res_o  (res_if)
  );

  record_t    records_to_send[$];
  group_row_t group_rows_owed[$];

  // predictor state for the open group and the current sequence
  logic [KEY_W-1:0] open_key;
  logic [SUM_W-1:0] open_sum;
  int               open_count;
  int               seq_seen;
  logic             seq_ovf;

  int errors;
  int records_queued;
  int records_taken;
  int records_dropped;
  int results_checked;
  int runs_closed;
  int largest_group;
  int drain_pauses;

  bit rec_took;
  bit res_took;
  int send_wait;
  int send_burst;
  int recv_wait;
  int recv_burst;
  int seq_no;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    if (errors < 100) $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // gap before the next handshake; sometimes a burst with no gaps at all
  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  task automatic emit_open_group(bit final_grp);
    group_row_t row;
    for (int k = 0; k < open_count; k++) begin
      row.key   = open_key;
      row.sum   = open_sum;
      row.count = CNT_W'(open_count);
      row.ovf   = seq_ovf;
      row.eor   = final_grp && (k == open_count - 1);
      group_rows_owed.push_back(row);
    end
    if (open_count > largest_group) largest_group = open_count;
  endtask

  task automatic fold_record(record_t r);
    logic [DISC_W-1:0] d;
    logic [PROD_W-1:0] prod;
    logic [SUM_W:0]    total;
    records_taken++;
    if (seq_seen >= MAX_RECORDS) begin
      seq_ovf = 1'b1;
      records_dropped++;
    end else begin
      if (open_count != 0 && r.key != open_key) begin
        emit_open_group(1'b0);
        open_sum   = '0;
        open_count = 0;
      end
      open_key = r.key;
      d        = (r.discount > ONE_Q16) ? ONE_Q16 : r.discount;
      prod     = PROD_W'(r.revenue) * PROD_W'(ONE_Q16 - d);
      total    = (SUM_W + 1)'(open_sum) + (SUM_W + 1)'(prod >> 16);
      if (total > (SUM_W + 1)'(SUM_MAX)) begin
        open_sum = SUM_MAX;
        seq_ovf  = 1'b1;
      end else begin
        open_sum = total[SUM_W-1:0];
      end
      open_count++;
      seq_seen++;
    end
    if (r.last) begin
      emit_open_group(1'b1);
      runs_closed++;
      open_key   = '0;
      open_sum   = '0;
      open_count = 0;
      seq_seen   = 0;
      seq_ovf    = 1'b0;
    end
  endtask

  task automatic check_result();
    group_row_t w;
    if (group_rows_owed.size() == 0) begin
      report_mismatch($sformatf("unexpected result key %h sum %h count %0d",
                                res_if.out_key, res_if.group_sum, res_if.group_count));
    end else begin
      w = group_rows_owed.pop_front();
      results_checked++;
      if (res_if.out_key !== w.key)
        report_mismatch($sformatf("out_key got %h want %h", res_if.out_key, w.key));
      if (res_if.group_sum !== w.sum)
        report_mismatch($sformatf("group_sum got %h want %h (key %h)",
                                  res_if.group_sum, w.sum, w.key));
      if (res_if.group_count !== w.count)
        report_mismatch($sformatf("group_count got %0d want %0d (key %h)",
                                  res_if.group_count, w.count, w.key));
      if (res_if.overflow !== w.ovf)
        report_mismatch($sformatf("overflow got %b want %b (key %h)",
                                  res_if.overflow, w.ovf, w.key));
      if (res_if.end_of_run !== w.eor)
        report_mismatch($sformatf("end_of_run got %b want %b (key %h)",
                                  res_if.end_of_run, w.eor, w.key));
    end
  endtask

  always @(posedge clk_i) begin
    rec_took <= rst_ni && rec_if.valid && rec_if.ready;
    res_took <= rst_ni && res_if.valid && res_if.ready;
    if (rst_ni && rec_if.valid && rec_if.ready) begin
      fold_record('{rec_if.key, rec_if.revenue, rec_if.discount, rec_if.last, 1'b0});
    end
    if (rst_ni && res_if.valid && res_if.ready) begin
      check_result();
    end
  end

  // record driver
  always @(negedge clk_i) begin
    record_t cur;
    if (rst_ni && (!rec_if.valid || rec_took)) begin
      if (rec_took) send_wait = draw_wait(send_burst);
      if (send_wait > 0) begin
        send_wait--;
        rec_if.valid <= 1'b0;
      end else if (records_to_send.size() != 0 &&
                   !(records_to_send[0].drain && group_rows_owed.size() != 0)) begin
        cur = records_to_send.pop_front();
        if (cur.drain) drain_pauses++;
        rec_if.key      <= cur.key;
        rec_if.revenue  <= cur.revenue;
        rec_if.discount <= cur.discount;
        rec_if.last     <= cur.last;
        rec_if.valid    <= 1'b1;
      end else begin
        rec_if.valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_took) recv_wait = draw_wait(recv_burst);
      if (recv_wait > 0) begin
        recv_wait--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic push_record(logic [KEY_W-1:0] key, logic [REV_W-1:0] rev,
                             logic [DISC_W-1:0] disc, logic last, bit drain);
    records_to_send.push_back('{key, rev, disc, last, drain});
    records_queued++;
  endtask

  function automatic logic [REV_W-1:0] pick_revenue();
    case ($urandom_range(0, 7))
      0: return '1;
      1: return '0;
      2: return REV_W'($urandom_range(0, 4096));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DISC_W-1:0] pick_discount();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ONE_Q16;
      2: return DISC_W'($urandom_range(65537, 131071));  // above one
      default: return DISC_W'($urandom_range(0, 65536));
    endcase
  endfunction

  // a key-sorted sequence with runs of equal keys, ended by last
  task automatic push_sorted_run(int n, int max_grp, bit one_key, bit drain);
    logic [KEY_W-1:0] k;
    int left;
    k    = {$urandom(), $urandom()};
    left = $urandom_range(1, max_grp);
    for (int i = 0; i < n; i++) begin
      if (!one_key && left == 0) begin
        if ($urandom_range(0, 3) == 0) k = k + {32'h0, $urandom()};
        else k = k + KEY_W'($urandom_range(1, 4));
        left = $urandom_range(1, max_grp);
      end
      push_record(k, pick_revenue(), pick_discount(), i == n - 1, drain && i == 0);
      left--;
    end
  endtask

  // unsorted keys drawn from a small pool, with stray last marks
  task automatic push_noise_run(int n, bit drain);
    logic [KEY_W-1:0] pool [3];
    for (int j = 0; j < 3; j++) pool[j] = {$urandom(), $urandom()};
    for (int i = 0; i < n; i++) begin
      push_record(pool[$urandom_range(0, 2)], pick_revenue(), pick_discount(),
                  (i == n - 1) || ($urandom_range(0, 9) == 0), drain && i == 0);
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    rec_if.valid    = 1'b0;
    rec_if.key      = '0;
    rec_if.revenue  = '0;
    rec_if.discount = '0;
    rec_if.last     = 1'b0;
    res_if.ready    = 1'b0;

    // directed: field extremes, discount at and above one, key change on last,
    // single-record run, reappearing key, descending keys
    push_record('0, '0, '0, 1'b0, 1'b0);
    push_record('0, '1, '0, 1'b0, 1'b0);
    push_record('0, '1, ONE_Q16, 1'b0, 1'b0);
    push_record(64'h1, '1, DISC_W'(65537), 1'b0, 1'b0);
    push_record(64'h1, 32'h8000_0001, '1, 1'b0, 1'b0);
    push_record(64'h5, 32'h0000_0100, DISC_W'(32768), 1'b1, 1'b0);
    push_record('1, '1, DISC_W'(1), 1'b1, 1'b0);
    push_record(64'd10, 32'h0000_0100, DISC_W'(16'hFFFF), 1'b0, 1'b1);
    push_record(64'd3, 32'h1234_5678, '0, 1'b0, 1'b0);
    push_record(64'd10, 32'hFFFF_FF00, DISC_W'(16384), 1'b1, 1'b0);
    push_record('1, 32'h5555_5555, DISC_W'(21845), 1'b0, 1'b0);
    push_record('1, 32'hAAAA_AAAA, DISC_W'(43690), 1'b0, 1'b0);
    push_record('0, 32'h0000_0001, '0, 1'b0, 1'b0);
    push_record(64'h5555_5555_5555_5555, '1, '0, 1'b0, 1'b0);
    push_record(64'hAAAA_AAAA_AAAA_AAAA, '1, DISC_W'(1), 1'b1, 1'b0);

    // capacity: a single key over the limit, then several keys with a dropped last
    push_sorted_run(70, 64, 1'b1, 1'b1);
    push_sorted_run(66, 6, 1'b0, 1'b0);
    push_sorted_run(64, 64, 1'b1, 1'b1);

    seq_no = 0;
    while (records_queued < 480) begin
      seq_no++;
      case ($urandom_range(0, 9))
        0, 1: push_noise_run($urandom_range(1, 12), seq_no % 7 == 0);
        2: push_sorted_run($urandom_range(63, 72), ($urandom_range(0, 1) != 0) ? 64 : 8,
                           $urandom_range(0, 2) == 0, seq_no % 7 == 0);
        default: push_sorted_run($urandom_range(1, 24), $urandom_range(1, 8), 1'b0,
                                 seq_no % 7 == 0);
      endcase
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (records_to_send.size() != 0 || rec_if.valid) @(posedge clk_i);
    while (group_rows_owed.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("covered %0d records in %0d sequences, %0d dropped past capacity",
             records_taken, runs_closed, records_dropped);
    $display("checked %0d results, largest group %0d, %0d drained pauses",
             results_checked, largest_group, drain_pauses);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #(12 * 3000000);
    $display("tb failed");
    $finish;
  end

endmodule

/* filelist.f */
design/skgs_pkg.sv
design/skgs_if.sv
design/skgs_mac.sv
design/sorted_key_group_sum_count.sv
test/tb.sv
